// ----- hw/rtl/aptp_pkg.sv -----
// Shared constants and types for the aging priority task picker.
package aptp_pkg;

	localparam int TASK_SLOTS = 16;
	localparam int SLOT_W     = $clog2(TASK_SLOTS);
	localparam int RANK_W     = SLOT_W;
	localparam int CNT_W      = $clog2(TASK_SLOTS + 1);

	localparam int OP_W    = 3;
	localparam int TSLOT_W = 4;
	localparam int PRIO_W  = 6;
	localparam int DYN_W   = 8;
	localparam int IDX_W   = (SLOT_W > TSLOT_W) ? SLOT_W : TSLOT_W;

	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 8;

	localparam logic signed [PRIO_W-1:0] PRIO_LO   = -6'sd20;
	localparam logic signed [PRIO_W-1:0] PRIO_HI   = 6'sd20;
	localparam logic signed [DYN_W-1:0]  DYN_FLOOR = -8'sd128;

	typedef enum logic [OP_W-1:0] {
		OP_CREATE   = 3'd0,
		OP_READY    = 3'd1,
		OP_REMOVE   = 3'd2,
		OP_SET_PRIO = 3'd3,
		OP_SCHEDULE = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_SCAN,
		ST_APPLY,
		ST_OUT
	} state_t;

endpackage

// ----- hw/rtl/aging_priority_task_picker.sv -----
// Task table with a slot-serial scheduler that picks the most urgent ready task and ages the rest.
// Sequence: an accepted command is run, a schedule then scans every slot and applies the pick,
// and each command ends by loading its result beat, which waits while the previous beat is unread.
// A new command is accepted only once the last one has loaded its beat. The schedule scan uses the
// single comparator that walks the task slots one per cycle through one table read port.
// Reset: arst_n clears the whole task table, the ready count, the sequencer and the output beat.
module aging_priority_task_picker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// operation[2:0], task_slot[6:3], priority_req[12:7], zeros[15:13]
	input  logic [aptp_pkg::S_DATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// found[0], chosen_slot[4:1], zeros[7:5]
	output logic [aptp_pkg::M_DATA_W-1:0] m_tdata
);
	import aptp_pkg::*;

	state_t state_q, state_d;

	logic                     ready_q   [TASK_SLOTS];
	logic signed [PRIO_W-1:0] static_q  [TASK_SLOTS];
	logic signed [DYN_W-1:0]  dynamic_q [TASK_SLOTS];
	logic [RANK_W-1:0]        rank_q    [TASK_SLOTS];
	logic [CNT_W-1:0]         count_q;

	logic [OP_W-1:0]          op_q;
	logic [SLOT_W-1:0]        tgt_q;
	logic                     tgt_ok_q;
	logic signed [PRIO_W-1:0] prio_q;

	logic [SLOT_W-1:0]        scan_idx_q;
	logic                     have_q;
	logic [SLOT_W-1:0]        win_q;
	logic signed [DYN_W-1:0]  best_dyn_q;
	logic [RANK_W-1:0]        best_rank_q;

	logic                     res_found_q;
	logic [TSLOT_W-1:0]       res_slot_q;
	logic                     m_tvalid_q;
	logic [M_DATA_W-1:0]      m_tdata_q;

	logic                     accept;
	logic                     run_en;
	logic                     scan_en;
	logic                     apply_en;
	logic                     out_load;
	logic                     scan_last;

	logic [IDX_W-1:0]         in_slot_ext;
	logic [SLOT_W-1:0]        rd_idx;
	logic                     rd_ready;
	logic signed [PRIO_W-1:0] rd_static;
	logic signed [DYN_W-1:0]  rd_dyn;
	logic [RANK_W-1:0]        rd_rank;
	logic                     scan_better;
	logic                     prio_ok;
	logic [IDX_W-1:0]         win_ext;

	assign in_slot_ext = IDX_W'(s_tdata[6:3]);
	assign scan_last   = (scan_idx_q == SLOT_W'(TASK_SLOTS - 1));
	assign prio_ok     = (prio_q >= PRIO_LO) && (prio_q <= PRIO_HI);
	assign win_ext     = IDX_W'(win_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (op_q == OP_SCHEDULE) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		run_en   = 1'b0;
		scan_en  = 1'b0;
		apply_en = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE:  s_tready = 1'b1;
			ST_RUN:   run_en   = 1'b1;
			ST_SCAN:  scan_en  = 1'b1;
			ST_APPLY: apply_en = 1'b1;
			ST_OUT:   out_load = !m_tvalid_q || m_tready;
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	assign accept = s_tvalid && s_tready;

	always_comb begin
		if (scan_en) begin
			rd_idx = scan_idx_q;
		end else if (apply_en) begin
			rd_idx = win_q;
		end else begin
			rd_idx = tgt_q;
		end
	end

	assign rd_ready  = ready_q[rd_idx];
	assign rd_static = static_q[rd_idx];
	assign rd_dyn    = dynamic_q[rd_idx];
	assign rd_rank   = rank_q[rd_idx];

	assign scan_better = rd_ready && (!have_q || (rd_dyn < best_dyn_q) ||
		((rd_dyn == best_dyn_q) && (rd_rank < best_rank_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= s_tdata[2:0];
			tgt_q    <= in_slot_ext[SLOT_W-1:0];
			tgt_ok_q <= ({1'b0, in_slot_ext} < (IDX_W + 1)'(TASK_SLOTS));
			prio_q   <= $signed(s_tdata[12:7]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q  <= '0;
			have_q      <= 1'b0;
			win_q       <= '0;
			best_dyn_q  <= '0;
			best_rank_q <= '0;
		end else if (run_en) begin
			scan_idx_q  <= '0;
			have_q      <= 1'b0;
			win_q       <= '0;
			best_dyn_q  <= '0;
			best_rank_q <= '0;
		end else if (scan_en) begin
			scan_idx_q <= scan_idx_q + SLOT_W'(1);
			if (scan_better) begin
				have_q      <= 1'b1;
				win_q       <= scan_idx_q;
				best_dyn_q  <= rd_dyn;
				best_rank_q <= rd_rank;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TASK_SLOTS; i++) begin
				ready_q[i]   <= 1'b0;
				static_q[i]  <= '0;
				dynamic_q[i] <= '0;
				rank_q[i]    <= '0;
			end
			count_q <= '0;
		end else if (run_en && tgt_ok_q) begin
			case (op_q)
				OP_CREATE: begin
					static_q[tgt_q]  <= '0;
					dynamic_q[tgt_q] <= '0;
					if (!rd_ready) begin
						ready_q[tgt_q] <= 1'b1;
						rank_q[tgt_q]  <= count_q[RANK_W-1:0];
						count_q        <= count_q + CNT_W'(1);
					end
				end
				OP_READY: begin
					if (!rd_ready) begin
						ready_q[tgt_q] <= 1'b1;
						rank_q[tgt_q]  <= count_q[RANK_W-1:0];
						count_q        <= count_q + CNT_W'(1);
					end
				end
				OP_REMOVE: begin
					if (rd_ready) begin
						for (int i = 0; i < TASK_SLOTS; i++) begin
							if (ready_q[i] && (tgt_q != SLOT_W'(i)) && (rank_q[i] > rd_rank)) begin
								rank_q[i] <= rank_q[i] - RANK_W'(1);
							end
						end
						ready_q[tgt_q] <= 1'b0;
						rank_q[tgt_q]  <= '0;
						if (count_q != '0) begin
							count_q <= count_q - CNT_W'(1);
						end
					end
				end
				OP_SET_PRIO: begin
					if (prio_ok) begin
						static_q[tgt_q] <= prio_q;
					end
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end else if (apply_en && have_q) begin
			for (int i = 0; i < TASK_SLOTS; i++) begin
				if (ready_q[i] && (win_q != SLOT_W'(i))) begin
					if (dynamic_q[i] > DYN_FLOOR) begin
						dynamic_q[i] <= dynamic_q[i] - DYN_W'(1);
					end
					if (rank_q[i] > best_rank_q) begin
						rank_q[i] <= rank_q[i] - RANK_W'(1);
					end
				end
			end
			dynamic_q[win_q] <= DYN_W'(rd_static);
			ready_q[win_q]   <= 1'b0;
			rank_q[win_q]    <= '0;
			if (count_q != '0) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run_en) begin
			res_found_q <= 1'b0;
			res_slot_q  <= '0;
		end else if (apply_en) begin
			res_found_q <= have_q;
			res_slot_q  <= have_q ? win_ext[TSLOT_W-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= M_DATA_W'({res_slot_q, res_found_q});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ----- bench/aptp_checker.sv -----
// Checker for the aging priority task picker: predicts every result beat and compares it.
`timescale 1ns / 1ps
module aptp_checker
	import aptp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [M_DATA_W-1:0] m_tdata,
	output int unsigned         outstanding,
	output int unsigned         fail_count
);

	typedef struct packed {
		logic               found;
		logic [TSLOT_W-1:0] chosen;
	} pick_t;

	logic                     ready_q   [TASK_SLOTS];
	logic signed [PRIO_W-1:0] base_prio [TASK_SLOTS];
	logic signed [DYN_W-1:0]  age_prio  [TASK_SLOTS];
	logic [RANK_W-1:0]        rank_q    [TASK_SLOTS];
	int unsigned              ready_total;
	pick_t                    picks_due [$];

	task automatic join_ready(input int s);
		ready_q[s] = 1'b1;
		rank_q[s] = ready_total[RANK_W-1:0];
		ready_total++;
	endtask

	task automatic leave_ready(input int s);
		logic [RANK_W-1:0] r;
		r = rank_q[s];
		for (int i = 0; i < TASK_SLOTS; i++)
			if (ready_q[i] && i != s && rank_q[i] > r)
				rank_q[i]--;
		ready_q[s] = 1'b0;
		rank_q[s] = '0;
		if (ready_total > 0)
			ready_total--;
	endtask

	task automatic apply_cmd(input logic [S_DATA_W-1:0] cmd, output pick_t res);
		logic [OP_W-1:0]          opb;
		logic [TSLOT_W-1:0]       slot;
		logic signed [PRIO_W-1:0] prio;
		bit                       hit;
		bit                       have;
		int                       win;
		opb  = cmd[OP_W-1:0];
		slot = cmd[OP_W +: TSLOT_W];
		prio = signed'(cmd[OP_W+TSLOT_W +: PRIO_W]);
		hit  = slot < TASK_SLOTS;
		res  = '0;
		case (op_t'(opb))
			OP_CREATE: begin
				if (hit) begin
					base_prio[slot] = '0;
					age_prio[slot] = '0;
					if (!ready_q[slot])
						join_ready(slot);
				end
			end
			OP_READY: begin
				if (hit && !ready_q[slot])
					join_ready(slot);
			end
			OP_REMOVE: begin
				if (hit && ready_q[slot])
					leave_ready(slot);
			end
			OP_SET_PRIO: begin
				if (hit && prio >= PRIO_LO && prio <= PRIO_HI)
					base_prio[slot] = prio;
			end
			OP_SCHEDULE: begin
				have = 1'b0;
				win = 0;
				for (int i = 0; i < TASK_SLOTS; i++) begin
					if (ready_q[i] && (!have || age_prio[i] < age_prio[win] ||
							(age_prio[i] == age_prio[win] && rank_q[i] < rank_q[win]))) begin
						win = i;
						have = 1'b1;
					end
				end
				if (have) begin
					for (int i = 0; i < TASK_SLOTS; i++)
						if (ready_q[i] && i != win && age_prio[i] != DYN_FLOOR)
							age_prio[i]--;
					age_prio[win] = base_prio[win];
					leave_ready(win);
					res.found = 1'b1;
					res.chosen = win[TSLOT_W-1:0];
				end
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		pick_t due;
		pick_t seen;
		if (!arst_n) begin
			for (int i = 0; i < TASK_SLOTS; i++) begin
				ready_q[i] = 1'b0;
				base_prio[i] = '0;
				age_prio[i] = '0;
				rank_q[i] = '0;
			end
			ready_total = 0;
			picks_due.delete();
			fail_count = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				apply_cmd(s_tdata, due);
				picks_due.push_back(due);
			end
			if (m_tvalid && m_tready) begin
				seen.found = m_tdata[0];
				seen.chosen = m_tdata[TSLOT_W:1];
				if (picks_due.size() == 0) begin
					$error("unexpected result beat: found %0d, chosen_slot %0d",
						seen.found, seen.chosen);
					fail_count++;
				end else begin
					due = picks_due.pop_front();
					if (seen.found !== due.found) begin
						$error("found: expected %0d, actual %0d", due.found, seen.found);
						fail_count++;
					end
					if (seen.chosen !== due.chosen) begin
						$error("chosen_slot: expected %0d, actual %0d", due.chosen, seen.chosen);
						fail_count++;
					end
				end
			end
		end
		outstanding = picks_due.size();
	end

endmodule

// ----- bench/aging_priority_task_picker_test.sv -----
// Testbench top for the aging priority task picker: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module aging_priority_task_picker_test;
	import aptp_pkg::*;

	localparam int ITEM_COUNT  = 1950;
	localparam int BLOCK_LEN   = 150;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SINK_HOLD   = 400;
	localparam int SETTLE      = 64;

	localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_MID   = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	int unsigned         outstanding;
	int unsigned         fail_count;
	int unsigned         cycle_count = 0;
	bit                  quiet = 1'b0;
	bit                  hold_req = 1'b0;

	aging_priority_task_picker DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	aptp_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("aging_priority_task_picker_test: done, errors");
			$finish;
		end
	end

	function automatic int unsigned idle_len();
		return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 30);
	endfunction

	// receiver: random stalls, one long hold on request
	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (SINK_HOLD) @(negedge clk);
				hold_req = 1'b0;
				m_tready <= 1'b1;
			end else if (quiet || $urandom_range(0, 3) != 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				repeat (idle_len() - 1) @(negedge clk);
			end
		end
	end

	task automatic send_cmd(input logic [OP_W-1:0] op, input logic [TSLOT_W-1:0] slot,
			input logic [PRIO_W-1:0] prio);
		int unsigned gap;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {{(S_DATA_W - OP_W - TSLOT_W - PRIO_W){1'b0}}, prio, slot, op};
		do @(posedge clk); while (!s_tready);
		gap = (!quiet && $urandom_range(0, 3) == 0) ? idle_len() : 0;
		if (gap != 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic random_cmd(output logic [OP_W-1:0] op, output logic [TSLOT_W-1:0] slot,
			output logic [PRIO_W-1:0] prio);
		int unsigned pick;
		int          level;
		pick = $urandom_range(0, 99);
		slot = TSLOT_W'($urandom_range(0, TASK_SLOTS - 1));
		prio = PRIO_W'($urandom);
		if (pick < 12) begin
			op = OP_CREATE;
		end else if (pick < 37) begin
			op = OP_READY;
		end else if (pick < 47) begin
			op = OP_REMOVE;
		end else if (pick < 61) begin
			op = OP_SET_PRIO;
			if ($urandom_range(0, 4) != 0)
				level = int'($urandom_range(0, 40)) - 20;
			else if ($urandom_range(0, 1) != 0)
				level = int'($urandom_range(21, 31));
			else
				level = -int'($urandom_range(21, 32));
			prio = PRIO_W'(level);
		end else if (pick < 96) begin
			op = OP_SCHEDULE;
		end else begin
			op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
		end
	endtask

	initial begin
		logic [OP_W-1:0]    op;
		logic [TSLOT_W-1:0] slot;
		logic [PRIO_W-1:0]  prio;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_cmd(OP_SCHEDULE, 4'd0, '0);
		send_cmd(OP_CREATE, 4'd0, '0);
		send_cmd(OP_CREATE, 4'd15, '0);
		send_cmd(OP_SET_PRIO, 4'd15, PRIO_LO);
		send_cmd(OP_SET_PRIO, 4'd0, PRIO_HI);
		send_cmd(OP_SET_PRIO, 4'd0, PRIO_LO - 6'sd1);
		send_cmd(OP_SET_PRIO, 4'd15, PRIO_HI + 6'sd1);
		send_cmd(OP_SET_PRIO, 4'd3, 6'b100000);
		send_cmd(OP_CREATE, 4'd5, '0);
		send_cmd(OP_READY, 4'd5, '0);
		send_cmd(OP_SET_PRIO, 4'd5, -6'sd7);
		send_cmd(OP_CREATE, 4'd5, 6'b111111);
		send_cmd(OP_REMOVE, 4'd9, '0);
		send_cmd(OP_SPARE_FIRST, 4'd9, '0);
		send_cmd(OP_SPARE_MID, 4'd10, 6'b010101);
		send_cmd(OP_SPARE_LAST, 4'd15, 6'b111111);
		send_cmd(OP_READY, 4'd9, '0);
		send_cmd(OP_SCHEDULE, 4'd0, '0);
		send_cmd(OP_SCHEDULE, 4'd0, '0);
		send_cmd(OP_REMOVE, 4'd5, '0);
		send_cmd(OP_READY, 4'd0, '0);
		send_cmd(OP_SCHEDULE, 4'd0, '0);
		send_cmd(OP_SCHEDULE, 4'd0, '0);
		send_cmd(OP_SCHEDULE, 4'd0, '0);

		for (int b = 0; b * BLOCK_LEN < ITEM_COUNT; b++) begin
			quiet = (b % 4 == 1);
			if (b == 3)
				hold_req = 1'b1;
			if (b == 6)
				drain();
			for (int k = 0; k < BLOCK_LEN; k++) begin
				random_cmd(op, slot, prio);
				send_cmd(op, slot, prio);
			end
		end

		drain();
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("aging_priority_task_picker_test: done, clean");
		else
			$display("aging_priority_task_picker_test: done, errors");
		$finish;
	end

endmodule
